[hw/rtl/ufd_pkg.sv]
// Shared types and constants for the unpacked float divide unit.
`timescale 1ns / 1ps
package ufd_pkg;

  localparam int FracW  = 61;
  localparam int RemW   = 64;
  localparam int ExpInW = 12;
  localparam int ExpW   = 13;
  localparam int OutFracW = 62;
  localparam int Steps  = FracW;

  localparam logic [2:0] ClsZero   = 3'd2;
  localparam logic [2:0] ClsNumber = 3'd3;
  localparam logic [2:0] ClsInf    = 3'd4;

  localparam logic [7:0] GuardHalf = 8'h80;

  typedef struct packed {
    logic                   vld;
    logic                   special;
    logic                   dnan;
    logic [2:0]             cls;
    logic                   sign;
    logic signed [ExpW-1:0] exp;
    logic [RemW-1:0]        rem;
    logic [FracW-1:0]       den;
    logic [FracW-1:0]       quo;
  } ufd_item_t;

endpackage

[hw/rtl/ufd_div_step.sv]
// One registered restoring division step of the quotient pipeline.
`timescale 1ns / 1ps
module ufd_div_step import ufd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  ufd_item_t item_i,
  output ufd_item_t item_o
);

  ufd_item_t item_d, item_q;
  logic [RemW-1:0] den_ext;
  logic            ge;

  always_comb begin
    den_ext = {{(RemW-FracW){1'b0}}, item_i.den};
    ge      = item_i.rem >= den_ext;
    item_d  = item_i;
    if (!item_i.special) begin
      item_d.quo = {item_i.quo[FracW-2:0], ge};
      item_d.rem = (ge ? (item_i.rem - den_ext) : item_i.rem) << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

[hw/rtl/unpacked_float_divide_unit.sv]
// Top level of the pipelined unpacked double divider.
`timescale 1ns / 1ps
// Divides two unpacked doubles (class, sign, exponent, 61-bit fraction) with
// soft-float special-case handling and round-half-to-even on 8 guard bits.
// One item is accepted every cycle unless in_stall_o is high; each item passes
// through one decode stage, 61 restoring division stages (one quotient bit
// and one 64-bit subtract each) and one rounding stage. While a result waits
// under out_stall_i the whole pipeline holds.
module unpacked_float_divide_unit import ufd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                a_class_i,
  input  logic                      a_sign_i,
  input  logic signed [ExpInW-1:0]  a_exponent_i,
  input  logic [FracW-1:0]          a_fraction_i,
  input  logic [2:0]                b_class_i,
  input  logic                      b_sign_i,
  input  logic signed [ExpInW-1:0]  b_exponent_i,
  input  logic [FracW-1:0]          b_fraction_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                r_class_o,
  output logic                      r_sign_o,
  output logic signed [ExpW-1:0]    r_exponent_o,
  output logic [OutFracW-1:0]       r_fraction_o,
  output logic                      default_nan_o
);

  logic      adv;
  ufd_item_t dec_d, dec_q;
  ufd_item_t stg [Steps+1];

  logic                   out_vld_q;
  logic [2:0]             cls_q;
  logic                   sign_q, dnan_q;
  logic signed [ExpW-1:0] exp_q;
  logic [OutFracW-1:0]    frac_d, frac_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    logic signed [ExpW-1:0] ediff;
    ediff = ExpW'(a_exponent_i) - ExpW'(b_exponent_i);
    dec_d         = '0;
    dec_d.vld     = in_valid_i;
    dec_d.special = 1'b1;
    dec_d.den     = b_fraction_i;
    dec_d.sign    = a_sign_i ^ b_sign_i;
    if (a_class_i inside {[3'd0:3'd1]}) begin
      dec_d.cls  = a_class_i;
      dec_d.sign = a_sign_i;
      dec_d.exp  = ExpW'(a_exponent_i);
      dec_d.quo  = a_fraction_i;
    end else if (b_class_i inside {[3'd0:3'd1]}) begin
      dec_d.cls  = b_class_i;
      dec_d.sign = b_sign_i;
      dec_d.exp  = ExpW'(b_exponent_i);
      dec_d.quo  = b_fraction_i;
    end else if (a_class_i == ClsInf || a_class_i == ClsZero) begin
      if (a_class_i == b_class_i) begin
        dec_d.dnan = 1'b1;
        dec_d.sign = 1'b0;
      end else begin
        dec_d.cls = a_class_i;
        dec_d.exp = ExpW'(a_exponent_i);
        dec_d.quo = a_fraction_i;
      end
    end else if (b_class_i == ClsInf) begin
      dec_d.cls = a_class_i;
    end else if (b_class_i == ClsZero) begin
      dec_d.cls = ClsInf;
      dec_d.exp = ExpW'(a_exponent_i);
      dec_d.quo = a_fraction_i;
    end else begin
      dec_d.special = 1'b0;
      dec_d.cls     = a_class_i;
      if (a_fraction_i < b_fraction_i) begin
        dec_d.rem = {{(RemW-FracW-1){1'b0}}, a_fraction_i, 1'b0};
        dec_d.exp = ediff - ExpW'(1);
      end else begin
        dec_d.rem = {{(RemW-FracW){1'b0}}, a_fraction_i};
        dec_d.exp = ediff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= '0;
    end else if (adv) begin
      dec_q <= dec_d;
    end
  end

  assign stg[0] = dec_q;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    ufd_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .item_i (stg[i]),
      .item_o (stg[i+1])
    );
  end

  always_comb begin
    ufd_item_t fin;
    fin    = stg[Steps];
    frac_d = {1'b0, fin.quo};
    if (!fin.special && fin.quo[7:0] == GuardHalf &&
        (fin.quo[8] || fin.rem != '0)) begin
      frac_d = {1'b0, fin.quo} + OutFracW'(GuardHalf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= stg[Steps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q  <= stg[Steps].cls;
      sign_q <= stg[Steps].sign;
      exp_q  <= stg[Steps].exp;
      dnan_q <= stg[Steps].dnan;
      frac_q <= frac_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign r_class_o     = cls_q;
  assign r_sign_o      = sign_q;
  assign r_exponent_o  = exp_q;
  assign r_fraction_o  = frac_q;
  assign default_nan_o = dnan_q;

endmodule

[hw/rtl/ufd_checker.sv]
// Port-level checker for the unpacked float divide unit, with its bind.
`timescale 1ns / 1ps
module ufd_checker import ufd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [2:0]             r_class_o,
  input logic                   r_sign_o,
  input logic signed [ExpW-1:0] r_exponent_o,
  input logic [OutFracW-1:0]    r_fraction_o,
  input logic                   default_nan_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_dnan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && default_nan_o |-> r_class_o == '0 && !r_sign_o &&
      r_exponent_o == '0 && r_fraction_o == '0)
    else $error("default NaN with nonzero fields");

  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind unpacked_float_divide_unit ufd_checker u_ufd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .r_class_o     (r_class_o),
  .r_sign_o      (r_sign_o),
  .r_exponent_o  (r_exponent_o),
  .r_fraction_o  (r_fraction_o),
  .default_nan_o (default_nan_o)
);
